// File: rtl/core/fcc_pkg.sv
package fcc_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int VTX_W            = 6;
    localparam int WGT_W            = 16;
    localparam int NC_W             = 7;
    localparam int CNT_W            = 24;
    localparam int CHUNK_W          = 8;
    localparam int CHUNK_CNT_W      = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_COUNT = 1'b1;

    // edge write into the adjacency store
    typedef struct packed {
        logic             en;
        logic [VTX_W-1:0] row;
        logic [VTX_W-1:0] col;
        logic             val;
    } t_wr_req;

    function automatic logic [CHUNK_CNT_W-1:0] pop8(input logic [CHUNK_W-1:0] v);
        logic [CHUNK_CNT_W-1:0] n;
        n = '0;
        for (int b = 0; b < CHUNK_W; b++) begin
            n = n + CHUNK_CNT_W'(v[b]);
        end
        return n;
    endfunction

endpackage

// File: rtl/core/fcc_adj_store.sv
module fcc_adj_store
    import fcc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_wr_req                         i_wr,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_rd_addr,
    output logic [MAX_VERTICES-1:0]         o_rd_data
);

    localparam int IW = $clog2(MAX_VERTICES);

    logic [MAX_VERTICES-1:0] r_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_vld;
    logic [MAX_VERTICES-1:0] r_rd_data;
    logic [IW-1:0]           wa;
    logic [IW-1:0]           wc;

    assign wa = IW'(i_wr.row);
    assign wc = IW'(i_wr.col);

    // a row never written reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            for (int b = 0; b < MAX_VERTICES; b++) begin
                if (!r_vld[wa] || IW'(b) == wc) begin
                    r_mem[wa][b] <= (IW'(b) == wc) ? i_wr.val : 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/four_clique_counter.sv
// Directed four-clique counter. Edge loads (tuser 0) write one presence bit of an
// adjacency matrix held in a row memory with one write port and one read port, and
// loads stream back to back while no count runs. A count request (tuser 1) walks
// every row pair (i,j) below L = min(node_count-1, MAX_VERTICES), reading its rows
// from that memory, and for each present edge i->j sweeps all rows k below L
// through one shared and-popcount-accumulate unit. When node_count is below 2 a
// count goes straight to completion with a zero result. Either way a count is held
// up while the previous result still waits in the output register, and the block
// is not ready until the result is taken into that register. The matrix reads
// as empty after reset with no clearing pass.
// Counts above 16777215 saturate.
module four_clique_counter
    import fcc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [NC_W-1:0]  i_cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,    // src_vertex, dst_vertex, edge_weight
    input  logic             s_tuser,    // req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [CNT_W-1:0] m_tdata     // clique_count
);

    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int LW  = $clog2(MAX_VERTICES + 1);
    localparam int CW  = (LW > NC_W) ? LW : NC_W;
    localparam int NCH = (MAX_VERTICES + CHUNK_W - 1) / CHUNK_W;
    localparam int PW  = $clog2(MAX_VERTICES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RDI, S_RDJ, S_CIJ, S_K, S_DRAIN, S_DONE
    } t_state;

    t_state                    r_state;
    logic [NC_W-1:0]           r_node_count;
    logic [IW-1:0]             r_i, r_j, r_k, r_last;
    logic [MAX_VERTICES-1:0]   r_mask, r_row_i, r_cij;
    logic [NCH*CHUNK_W-1:0]    r_and;
    logic [CHUNK_CNT_W-1:0]    r_cnt [NCH];
    logic [CNT_W-1:0]          r_total;
    logic                      r_drain;
    logic                      r_out_v;
    logic [CNT_W-1:0]          r_out_data;

    logic                      s_acc;
    logic [VTX_W-1:0]          in_src, in_dst;
    logic [WGT_W-1:0]          in_wgt;
    t_wr_req                   wr;
    logic [IW-1:0]             rd_addr;
    logic [MAX_VERTICES-1:0]   rd_data;
    logic [CW-1:0]             lim_raw, lim;
    logic [PW-1:0]             part_sum;
    logic [CNT_W:0]            sum_next;

    assign in_src = s_tdata[5:0];
    assign in_dst = s_tdata[11:6];
    assign in_wgt = s_tdata[27:12];

    assign s_tready = (r_state == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = r_out_v;
    assign m_tdata  = r_out_data;

    always_comb begin
        wr.en  = s_acc && (s_tuser == REQ_LOAD)
                 && (32'(in_src) < MAX_VERTICES) && (32'(in_dst) < MAX_VERTICES);
        wr.row = in_src;
        wr.col = in_dst;
        wr.val = !in_wgt[WGT_W-1] && (|in_wgt);
    end

    always_comb begin
        case (r_state)
            S_RDI:   rd_addr = r_i;
            S_RDJ:   rd_addr = r_j;
            S_K:     rd_addr = r_k + 1'b1;
            default: rd_addr = '0;
        endcase
    end

    fcc_adj_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // examined index range
    always_comb begin
        lim_raw = CW'(r_node_count) - 1'b1;
        lim     = (lim_raw > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : lim_raw;
    end

    always_comb begin
        part_sum = '0;
        for (int c = 0; c < NCH; c++) begin
            part_sum = part_sum + PW'(r_cnt[c]);
        end
        sum_next = {1'b0, r_total} + (CNT_W + 1)'(part_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    // popcount pipeline: and stage, chunk count stage, accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_and <= '0;
            for (int c = 0; c < NCH; c++) begin
                r_cnt[c] <= '0;
            end
        end else begin
            if (r_state == S_K && r_cij[r_k]) begin
                r_and <= (NCH*CHUNK_W)'(r_cij & rd_data);
            end else begin
                r_and <= '0;
            end
            for (int c = 0; c < NCH; c++) begin
                r_cnt[c] <= pop8(r_and[c*CHUNK_W +: CHUNK_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_v    <= 1'b0;
            r_total    <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_last     <= '0;
            r_drain    <= 1'b0;
        end else begin
            if (m_tready && r_state != S_DONE) begin
                r_out_v <= 1'b0;
            end
            if (s_acc && s_tuser == REQ_COUNT) begin
                r_total <= '0;
            end else if (sum_next > (CNT_W + 1)'(COUNT_MAX)) begin
                r_total <= COUNT_MAX;
            end else begin
                r_total <= sum_next[CNT_W-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc && s_tuser == REQ_COUNT) begin
                        for (int b = 0; b < MAX_VERTICES; b++) begin
                            r_mask[b] <= (CW'(b) < lim);
                        end
                        r_i    <= '0;
                        r_j    <= '0;
                        r_last <= IW'(lim - 1'b1);
                        if (r_node_count < NC_W'(2)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RDI;
                        end
                    end
                end
                S_RDI: begin
                    r_state <= S_RDJ;
                end
                S_RDJ: begin
                    if (r_j == '0) begin
                        r_row_i <= rd_data;
                    end
                    r_state <= S_CIJ;
                end
                S_CIJ: begin
                    r_cij <= r_row_i & rd_data & r_mask;
                    r_k   <= '0;
                    if (r_row_i[r_j]) begin
                        r_state <= S_K;
                    end else if (r_j != r_last) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RDJ;
                    end else if (r_i != r_last) begin
                        r_i     <= r_i + 1'b1;
                        r_j     <= '0;
                        r_state <= S_RDI;
                    end else begin
                        r_drain <= 1'b0;
                        r_state <= S_DRAIN;
                    end
                end
                S_K: begin
                    if (r_k != r_last) begin
                        r_k <= r_k + 1'b1;
                    end else if (r_j != r_last) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RDJ;
                    end else if (r_i != r_last) begin
                        r_i     <= r_i + 1'b1;
                        r_j     <= '0;
                        r_state <= S_RDI;
                    end else begin
                        r_drain <= 1'b0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_drain <= 1'b1;
                    if (r_drain) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_v || m_tready) begin
                        r_out_data <= r_total;
                        r_out_v    <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_K) |-> (r_k <= r_last))
        else $error("k index beyond examined range");

    a_small_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_tuser == REQ_COUNT && r_node_count < NC_W'(2)) |=>
        (r_state == S_DONE && r_total == '0))
        else $error("small vertex count did not finish with zero");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside completion");

    a_no_write_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (r_state == S_IDLE))
        else $error("edge write during count");

endmodule
